// File: rtl/core/gsfc_pkg.sv
package gsfc_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  localparam logic [7:0] CRC_POLY      = 8'h31;
  localparam logic [7:0] CRC_INIT      = 8'hFF;
  localparam logic [7:0] UNIT_FIELD    = 8'h0E;
  localparam logic [7:0] NOT_READY_BIT = 8'h01;

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_BEGIN = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;
  localparam logic [1:0] REQ_BYTE  = 2'd3;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NO_PREHEAT = 3'd1;
  localparam logic [2:0] ST_TOO_SOON   = 3'd2;
  localparam logic [2:0] ST_NOT_READY  = 3'd3;
  localparam logic [2:0] ST_WRONG_UNIT = 3'd4;
  localparam logic [2:0] ST_CRC_BAD    = 3'd5;
  localparam logic [2:0] ST_BEGUN      = 3'd6;

  localparam logic [1:0] CFG_UNIT     = 2'd0;
  localparam logic [1:0] CFG_PREHEAT  = 2'd1;
  localparam logic [1:0] CFG_INTERVAL = 2'd2;
  localparam logic [1:0] CFG_STARTUP  = 2'd3;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_FRAME  = 1'b1;

  typedef enum logic [1:0] {
    OP_STATUS = 2'd0,
    OP_FRAME  = 2'd1,
    OP_ARM    = 2'd2,
    OP_BYTE   = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  tx_byte;
    logic [2:0]  status;
    logic [23:0] value;
    logic        last;
  } out_item_t;

  typedef struct packed {
    op_t        op;
    logic [2:0] code;
    logic [7:0] data;
  } cmd_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] c, input logic [7:0] b);
    logic [7:0] r;
    r = c ^ b;
    for (int i = 0; i < 8; i++) begin
      r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    end
    return r;
  endfunction

  function automatic logic [7:0] unit_byte(input logic [2:0] unit);
    return {4'b0000, unit, 1'b0};
  endfunction

endpackage

// File: rtl/core/gsfc_front.sv
module gsfc_front
  import gsfc_pkg::*;
#(
  parameter int TIME_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  in_item_t  in_data,
  output logic      in_stall,
  input  logic [19:0] preheat_ticks,
  input  logic [15:0] interval_ticks,
  input  logic [15:0] startup_extra_ticks,
  input  logic      q_full,
  output logic      q_push,
  output cmd_t      q_cmd
);

  logic [TIME_WIDTH-1:0] uptime_r, uptime_nxt;
  logic [TIME_WIDTH-1:0] last_start_r, last_start_nxt;
  logic                  started_r, started_nxt;
  logic [TIME_WIDTH-1:0] diff;
  logic                  acc;
  logic                  no_preheat, too_soon;

  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;

  assign diff       = uptime_r - last_start_r;
  assign no_preheat = uptime_r <= TIME_WIDTH'(preheat_ticks);
  assign too_soon   = !started_r || diff[TIME_WIDTH-1] ||
                      (diff < TIME_WIDTH'(interval_ticks));

  always_comb begin
    uptime_nxt     = uptime_r;
    last_start_nxt = last_start_r;
    started_nxt    = started_r;
    q_push         = 1'b0;
    q_cmd.op       = OP_STATUS;
    q_cmd.code     = ST_OK;
    q_cmd.data     = in_data.data_byte;
    if (acc) begin
      case (in_data.req_type)
        REQ_TICK: begin
          uptime_nxt = uptime_r + TIME_WIDTH'(1);
        end
        REQ_BEGIN: begin
          q_push = 1'b1;
          if (started_r) begin
            q_cmd.code = ST_BEGUN;
          end else begin
            q_cmd.op       = OP_FRAME;
            started_nxt    = 1'b1;
            last_start_nxt = uptime_r + TIME_WIDTH'(startup_extra_ticks);
          end
        end
        REQ_READ: begin
          q_push = 1'b1;
          if (no_preheat) begin
            q_cmd.code = ST_NO_PREHEAT;
          end else if (too_soon) begin
            q_cmd.code = ST_TOO_SOON;
          end else begin
            q_cmd.op       = OP_ARM;
            last_start_nxt = uptime_r;
          end
        end
        default: begin
          q_push   = 1'b1;
          q_cmd.op = OP_BYTE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      uptime_r     <= '0;
      last_start_r <= '0;
      started_r    <= 1'b0;
    end else begin
      uptime_r     <= uptime_nxt;
      last_start_r <= last_start_nxt;
      started_r    <= started_nxt;
    end
  end

endmodule

// File: rtl/core/gsfc_cmd_fifo.sv
module gsfc_cmd_fifo
  import gsfc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  cmd_t           mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QAW:0]   count_r;

  assign full       = count_r == (QAW+1)'(QDEPTH);
  assign head_valid = count_r != '0;
  assign head_cmd   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QAW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QAW'(1);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + (QAW+1)'(1);
        2'b01:   count_r <= count_r - (QAW+1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// File: rtl/core/gsfc_back.sv
module gsfc_back
  import gsfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [2:0] unit_code,
  input  logic       head_valid,
  input  cmd_t       head_cmd,
  output logic       pop,
  output logic       out_valid,
  output out_item_t  out_data,
  input  logic       out_stall
);

  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_r, out_nxt;
  logic       awaiting_r, awaiting_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic [7:0] crc_r, crc_nxt;
  logic [7:0] sbyte_r, sbyte_nxt;
  logic [23:0] value_r, value_nxt;
  logic [2:0] fidx_r, fidx_nxt;
  logic [7:0] fcrc_r, fcrc_nxt;
  logic       can_load, load;
  logic [7:0] u, nu, fbyte;
  logic [2:0] st;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign can_load  = !out_valid_r || !out_stall;

  assign u  = unit_byte(unit_code);
  assign nu = ~u;

  always_comb begin
    case (fidx_r)
      3'd0, 3'd2: fbyte = u;
      3'd1, 3'd3: fbyte = nu;
      default:    fbyte = fcrc_r;
    endcase
  end

  always_comb begin
    if (sbyte_r[0]) begin
      st = ST_NOT_READY;
    end else if ((sbyte_r & UNIT_FIELD) != u) begin
      st = ST_WRONG_UNIT;
    end else if (crc_r != head_cmd.data) begin
      st = ST_CRC_BAD;
    end else begin
      st = ST_OK;
    end
  end

  always_comb begin
    pop          = 1'b0;
    load         = 1'b0;
    out_nxt      = out_r;
    awaiting_nxt = awaiting_r;
    idx_nxt      = idx_r;
    crc_nxt      = crc_r;
    sbyte_nxt    = sbyte_r;
    value_nxt    = value_r;
    fidx_nxt     = fidx_r;
    fcrc_nxt     = fcrc_r;
    if (head_valid) begin
      case (head_cmd.op)
        OP_STATUS: begin
          if (can_load) begin
            load    = 1'b1;
            pop     = 1'b1;
            out_nxt = '{kind: KIND_STATUS, tx_byte: 8'h00, status: head_cmd.code,
                        value: 24'h0, last: 1'b1};
          end
        end
        OP_FRAME: begin
          if (can_load) begin
            load     = 1'b1;
            out_nxt  = '{kind: KIND_FRAME, tx_byte: fbyte, status: ST_OK,
                         value: 24'h0, last: fidx_r == 3'd4};
            fcrc_nxt = crc8_byte((fidx_r == 3'd0) ? CRC_INIT : fcrc_r, fbyte);
            fidx_nxt = fidx_r + 3'd1;
            if (fidx_r == 3'd4) begin
              pop      = 1'b1;
              fidx_nxt = 3'd0;
            end
          end
        end
        OP_ARM: begin
          pop          = 1'b1;
          awaiting_nxt = 1'b1;
          idx_nxt      = 3'd0;
          crc_nxt      = CRC_INIT;
          sbyte_nxt    = 8'h00;
          value_nxt    = 24'h0;
        end
        default: begin
          if (!awaiting_r) begin
            pop = 1'b1;
          end else if (idx_r != 3'd4) begin
            pop     = 1'b1;
            idx_nxt = idx_r + 3'd1;
            crc_nxt = crc8_byte(crc_r, head_cmd.data);
            if (idx_r == 3'd0) begin
              sbyte_nxt = head_cmd.data;
            end else begin
              value_nxt = {value_r[15:0], head_cmd.data};
            end
          end else if (can_load) begin
            pop          = 1'b1;
            load         = 1'b1;
            awaiting_nxt = 1'b0;
            idx_nxt      = 3'd0;
            out_nxt      = '{kind: KIND_STATUS, tx_byte: 8'h00, status: st,
                             value: (st == ST_OK) ? value_r : 24'h0, last: 1'b1};
          end
        end
      endcase
    end
  end

  assign out_valid_nxt = load ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    out_r   <= out_nxt;
    sbyte_r <= sbyte_nxt;
    value_r <= value_nxt;
    fcrc_r  <= fcrc_nxt;
    crc_r   <= crc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      awaiting_r  <= 1'b0;
      idx_r       <= 3'd0;
      fidx_r      <= 3'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      awaiting_r  <= awaiting_nxt;
      idx_r       <= idx_nxt;
      fidx_r      <= fidx_nxt;
    end
  end

endmodule

// File: rtl/core/gas_sensor_frame_checker_top.sv
// channel  ports                               direction
// in       in_valid, in_stall, in_data          requests and response bytes in
// out      out_valid, out_stall, out_data       transmit bytes and status out
// cfg      cfg_we, cfg_idx, cfg_wdata           register writes
// The front end takes one transaction per cycle while its 4-entry queue has room.
// Back end: one result per cycle unless stalled; a first begin emits a 5-byte frame.
// Back-end frame and response CRCs take one byte per cycle; out_stall holds the frame.
// rst_n is synchronous; config and control registers reset, data registers do not.
// in_stall rises only when the queue is full; out_stall holds output and new loads.
module gas_sensor_frame_checker_top
  import gsfc_pkg::*;
#(
  parameter int TIME_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  in_item_t    in_data,
  output logic        in_stall,
  output logic        out_valid,
  output out_item_t   out_data,
  input  logic        out_stall,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [19:0] cfg_wdata
);

  logic [2:0]  unit_code_r;
  logic [19:0] preheat_r;
  logic [15:0] interval_r;
  logic [15:0] startup_r;

  logic q_full, q_push, q_pop, q_head_valid;
  cmd_t q_cmd, q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_code_r <= 3'd0;
      preheat_r   <= 20'd120000;
      interval_r  <= 16'd1500;
      startup_r   <= 16'd500;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_UNIT:     unit_code_r <= cfg_wdata[2:0];
        CFG_PREHEAT:  preheat_r   <= cfg_wdata;
        CFG_INTERVAL: interval_r  <= cfg_wdata[15:0];
        default:      startup_r   <= cfg_wdata[15:0];
      endcase
    end
  end

  gsfc_front #(.TIME_WIDTH(TIME_WIDTH)) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_data            (in_data),
    .in_stall           (in_stall),
    .preheat_ticks      (preheat_r),
    .interval_ticks     (interval_r),
    .startup_extra_ticks(startup_r),
    .q_full             (q_full),
    .q_push             (q_push),
    .q_cmd              (q_cmd)
  );

  gsfc_cmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(q_head_valid),
    .head_cmd  (q_head)
  );

  gsfc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .unit_code (unit_code_r),
    .head_valid(q_head_valid),
    .head_cmd  (q_head),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import gsfc_pkg::*;

  localparam logic KIND_STAT = 1'b0;
  localparam logic KIND_TX   = 1'b1;

  localparam int DRAIN_CYCLES = 24;
  localparam int HOLD_CYCLES  = 150;
  localparam int STALL_LIMIT  = 3000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  in_item_t    in_data = '0;
  logic        in_stall;
  logic        out_valid;
  out_item_t   out_data;
  logic        out_stall = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = CFG_UNIT;
  logic [19:0] cfg_wdata = '0;

  gas_sensor_frame_checker_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // register shadows
  logic [2:0]  cfg_unit     = 3'd0;
  logic [19:0] cfg_preheat  = 20'd120000;
  logic [15:0] cfg_interval = 16'd1500;
  logic [15:0] cfg_startup  = 16'd500;

  // checker state as seen from the host
  logic [31:0] up_cnt     = '0;
  logic [31:0] arm_mark   = '0;
  logic        begun      = 1'b0;
  logic        collecting = 1'b0;
  logic [2:0]  byte_pos   = '0;
  logic [7:0]  crc_acc    = CRC_INIT;
  logic [7:0]  stat_byte  = '0;
  logic [23:0] value_acc  = '0;

  in_item_t  req_queue[$];
  out_item_t owed_results[$];

  int fault_count = 0;
  int pushed      = 0;
  int hold_asks   = 0;
  int hold_taken  = 0;
  int hold_left   = 0;
  int send_gap    = 0;
  int stall_left  = 0;
  int quiet_cnt   = 0;
  int idle_cycles = 0;

  function automatic logic [7:0] crc_mix(input logic [7:0] acc, input logic [7:0] din);
    logic [7:0] s;
    logic       fb;
    s = acc ^ din;
    for (int i = 0; i < 8; i++) begin
      fb = s[7];
      s  = {s[6:0], 1'b0};
      if (fb) s = s ^ CRC_POLY;
    end
    return s;
  endfunction

  function automatic logic [7:0] unit_field();
    return {4'b0000, cfg_unit, 1'b0} & UNIT_FIELD;
  endfunction

  function automatic void predict_txn(input in_item_t t);
    out_item_t   r;
    logic [7:0]  frame [5];
    logic [31:0] elapsed;
    r = '0;
    r.kind = KIND_STAT;
    r.last = 1'b1;
    case (t.req_type)
      REQ_TICK: up_cnt = up_cnt + 32'd1;
      REQ_BEGIN: begin
        if (begun) begin
          r.status = ST_BEGUN;
          owed_results.push_back(r);
        end else begin
          frame[0] = unit_field();
          frame[1] = ~frame[0];
          frame[2] = frame[0];
          frame[3] = frame[1];
          frame[4] = crc_mix(crc_mix(crc_mix(crc_mix(CRC_INIT, frame[0]), frame[1]),
                                     frame[2]), frame[3]);
          for (int i = 0; i < 5; i++) begin
            r.kind    = KIND_TX;
            r.tx_byte = frame[i];
            r.status  = ST_OK;
            r.last    = (i == 4);
            owed_results.push_back(r);
          end
          begun    = 1'b1;
          arm_mark = up_cnt + 32'(cfg_startup);
        end
      end
      REQ_READ: begin
        elapsed = up_cnt - arm_mark;
        if (up_cnt <= 32'(cfg_preheat)) begin
          r.status = ST_NO_PREHEAT;
          owed_results.push_back(r);
        end else if (!begun || elapsed[31] || elapsed < 32'(cfg_interval)) begin
          r.status = ST_TOO_SOON;
          owed_results.push_back(r);
        end else begin
          arm_mark   = up_cnt;
          collecting = 1'b1;
          byte_pos   = '0;
          crc_acc    = CRC_INIT;
          stat_byte  = '0;
          value_acc  = '0;
        end
      end
      default: begin
        if (collecting) begin
          if (byte_pos < 3'd4) begin
            if (byte_pos == 3'd0) stat_byte = t.data_byte;
            else value_acc = {value_acc[15:0], t.data_byte};
            crc_acc  = crc_mix(crc_acc, t.data_byte);
            byte_pos = byte_pos + 3'd1;
          end else begin
            if ((stat_byte & NOT_READY_BIT) != 8'h00) r.status = ST_NOT_READY;
            else if ((stat_byte & UNIT_FIELD) != unit_field()) r.status = ST_WRONG_UNIT;
            else if (crc_acc != t.data_byte) r.status = ST_CRC_BAD;
            else begin
              r.status = ST_OK;
              r.value  = value_acc;
            end
            owed_results.push_back(r);
            collecting = 1'b0;
            byte_pos   = '0;
          end
        end
      end
    endcase
  endfunction

  function automatic int pick_gap(input bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) quiet_cnt <= quiet_cnt + 1;

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_txn(in_data);
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (req_queue.size() != 0) begin
          in_data  <= req_queue.pop_front();
          in_valid <= 1'b1;
          send_gap = pick_gap(((quiet_cnt / 300) % 4) == 1);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  function automatic void note_fault(input string msg);
    if (fault_count < 10) $display("%0t: %s", $realtime, msg);
    fault_count++;
  endfunction

  // monitor
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          note_fault($sformatf("unexpected transaction kind=%0d tx=%02h st=%0d val=%06h last=%0d",
                               out_data.kind, out_data.tx_byte, out_data.status,
                               out_data.value, out_data.last));
        end else begin
          want = owed_results.pop_front();
          if (out_data.kind !== want.kind || out_data.tx_byte !== want.tx_byte ||
              out_data.status !== want.status || out_data.value !== want.value ||
              out_data.last !== want.last)
            note_fault($sformatf({"mismatch exp kind=%0d tx=%02h st=%0d val=%06h last=%0d",
                                  " got kind=%0d tx=%02h st=%0d val=%06h last=%0d"},
                                 want.kind, want.tx_byte, want.status, want.value, want.last,
                                 out_data.kind, out_data.tx_byte, out_data.status,
                                 out_data.value, out_data.last));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_taken != hold_asks) begin
        hold_taken++;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        stall_left = pick_gap(((quiet_cnt / 300) % 4) == 3);
        out_stall <= (stall_left > 0);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_req(input logic [1:0] req, input logic [7:0] d);
    in_item_t t;
    t.req_type  = req;
    t.data_byte = d;
    req_queue.push_back(t);
    pushed++;
  endtask

  task automatic push_ticks(input int n);
    for (int i = 0; i < n; i++) push_req(REQ_TICK, 8'($urandom));
  endtask

  // flaws: bit 0 not ready, bit 1 wrong unit, bit 2 bad crc
  task automatic push_reply(input logic [23:0] v, input logic [2:0] flaws, input int n_bytes);
    logic [7:0] b [5];
    b[0] = {4'($urandom), cfg_unit, 1'b0};
    if (flaws[0]) b[0][0] = 1'b1;
    if (flaws[1]) b[0][3:1] = cfg_unit ^ 3'($urandom_range(1, 7));
    b[1] = v[23:16];
    b[2] = v[15:8];
    b[3] = v[7:0];
    b[4] = crc_mix(crc_mix(crc_mix(crc_mix(CRC_INIT, b[0]), b[1]), b[2]), b[3]);
    if (flaws[2]) b[4] = b[4] ^ 8'($urandom_range(1, 255));
    for (int i = 0; i < n_bytes; i++) push_req(REQ_BYTE, b[i]);
  endtask

  task automatic set_reg(input logic [1:0] idx, input logic [19:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_UNIT:     cfg_unit     = val[2:0];
      CFG_PREHEAT:  cfg_preheat  = val;
      CFG_INTERVAL: cfg_interval = val[15:0];
      default:      cfg_startup  = val[15:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    while (req_queue.size() != 0 || in_valid || owed_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic random_phase(input int n_items);
    int          span, sel, n;
    logic [23:0] v;
    logic [2:0]  flaws;
    n = pushed + n_items;
    span = (cfg_interval > 16'd8) ? 8 : int'(cfg_interval);
    while (pushed < n) begin
      sel = $urandom_range(0, 9);
      if (sel < 7) begin
        if ($urandom_range(0, 4) == 0) push_ticks($urandom_range(0, span));
        else push_ticks(span + $urandom_range(1, 2));
        push_req(REQ_READ, 8'($urandom));
        case ($urandom_range(0, 7))
          0:       v = 24'h000000;
          1:       v = 24'hFFFFFF;
          default: v = 24'($urandom);
        endcase
        flaws = ($urandom_range(0, 9) < 6) ? 3'b000 : 3'($urandom_range(1, 7));
        push_reply(v, flaws, 5);
      end else if (sel == 7) begin
        push_ticks(span + 1);
        push_req(REQ_READ, 8'($urandom));
        push_reply(24'($urandom), 3'b000, $urandom_range(1, 4));
      end else begin
        repeat ($urandom_range(1, 3)) push_req(2'($urandom), 8'($urandom));
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // defaults: read before preheat, stray response byte
    push_req(REQ_READ, 8'h00);
    push_req(REQ_BYTE, 8'hFF);
    settle();

    set_reg(CFG_UNIT, 20'($urandom_range(0, 7)));
    set_reg(CFG_PREHEAT, 20'd2);
    set_reg(CFG_INTERVAL, 20'd3);
    set_reg(CFG_STARTUP, 20'd5);
    @(negedge clk);
    push_ticks(2);
    push_req(REQ_READ, 8'h00);
    push_ticks(1);
    push_req(REQ_READ, 8'hFF);
    push_req(REQ_BEGIN, 8'h00);
    push_req(REQ_BEGIN, 8'hFF);
    push_req(REQ_READ, 8'h00);
    push_ticks(7);
    push_req(REQ_READ, 8'h00);
    push_ticks(1);
    push_req(REQ_READ, 8'h00);
    push_reply(24'hFFFFFF, 3'b000, 5);
    settle();

    set_reg(CFG_INTERVAL, 20'd0);
    @(negedge clk);
    push_req(REQ_READ, 8'h00);
    push_reply(24'h123456, 3'b001, 5);
    push_req(REQ_READ, 8'h00);
    push_reply(24'h654321, 3'b010, 5);
    push_req(REQ_READ, 8'h00);
    push_reply(24'hA5A5A5, 3'b100, 5);
    push_req(REQ_READ, 8'h00);
    push_reply(24'h0F0F0F, 3'b000, 2);
    push_req(REQ_READ, 8'h00);
    push_reply(24'h000000, 3'b000, 5);
    settle();

    set_reg(CFG_UNIT, 20'($urandom_range(0, 7)));
    set_reg(CFG_PREHEAT, 20'($urandom_range(0, 10)));
    set_reg(CFG_INTERVAL, 20'($urandom_range(1, 6)));
    set_reg(CFG_STARTUP, 20'd0);
    @(negedge clk);
    random_phase(60);
    settle();

    set_reg(CFG_UNIT, 20'd7);
    set_reg(CFG_PREHEAT, 20'd0);
    set_reg(CFG_INTERVAL, 20'd0);
    @(negedge clk);
    random_phase(40);
    // output held off while begins keep coming, so the input side backs up
    hold_asks++;
    repeat (10) push_req(REQ_BEGIN, 8'($urandom));
    random_phase(40);
    settle();

    set_reg(CFG_UNIT, 20'd0);
    set_reg(CFG_PREHEAT, 20'd1000000);
    set_reg(CFG_INTERVAL, 20'd65535);
    set_reg(CFG_STARTUP, 20'd65535);
    @(negedge clk);
    random_phase(25);
    settle();

    set_reg(CFG_UNIT, 20'($urandom_range(0, 7)));
    set_reg(CFG_PREHEAT, 20'($urandom_range(0, 40)));
    set_reg(CFG_INTERVAL, 20'($urandom_range(0, 5)));
    set_reg(CFG_STARTUP, 20'($urandom_range(0, 65535)));
    @(negedge clk);
    random_phase(70);
    settle();

    fault_count += owed_results.size();
    if (fault_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
